// File: sv/stfp_pkg.sv
`default_nettype none
package stfp_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CountWidth = 4;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSep = 8'h3A;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] HourLimit = 8'd24;
  localparam logic [7:0] MinSecLimit = 8'd60;
  localparam logic [CountWidth-1:0] CountFull = CountWidth'(FrameLen);

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_LEN = 2'd1,
    STATUS_SEP = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  // Cell 0 holds the newest byte; after a full frame cell 7 holds the first one.
  typedef logic [FrameLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    status_t    frame_status;
  } result_t;

endpackage
`default_nettype wire

// File: sv/serial_time_frame_parser.sv
`default_nettype none
// Parses "HH:MM:SS" frames from a stream of received characters, one byte per
// cycle on the slave side while tready is high. Characters other than line
// feed and carriage return move along a row of eight byte cells; bytes beyond
// the eighth are dropped. A terminator yields one result transfer, registered
// into the output register, or into the skid register while the output holds
// an untaken result: status ok, wrong length, bad separators or out of range,
// with hours, minutes and seconds zero unless the status is ok. The registers
// let input flow while a result waits; tready falls only when both hold one.
module serial_time_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [1:0] frame_status, [9:2] hours,
                                      // [17:10] minutes, [25:18] seconds
);

  logic [stfp_pkg::CountWidth-1:0] char_count;
  stfp_pkg::frame_t  frame;
  stfp_pkg::result_t result;
  stfp_pkg::result_t out_data;
  stfp_pkg::result_t skid_data;
  logic out_valid;
  logic skid_valid;
  logic accept;
  logic term;
  logic full;
  logic shift;
  logic push;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign term     = (s_tdata == stfp_pkg::ChLf) || (s_tdata == stfp_pkg::ChCr);
  assign full     = (char_count == stfp_pkg::CountFull);
  assign shift    = accept && !term && !full;
  assign push     = accept && term;

  genvar i;
  generate
    for (i = 0; i < stfp_pkg::FrameLen; i++) begin : g_cell
      if (i == 0) begin : g_head
        stfp_cell u_cell (
          .clk   (clk),
          .shift (shift),
          .din   (s_tdata),
          .dout  (frame[i])
        );
      end else begin : g_body
        stfp_cell u_cell (
          .clk   (clk),
          .shift (shift),
          .din   (frame[i-1]),
          .dout  (frame[i])
        );
      end
    end
  endgenerate

  stfp_decode u_decode (
    .frame  (frame),
    .full   (full),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (accept) begin
      if (term) begin
        char_count <= '0;
      end else if (!full) begin
        char_count <= char_count + 1'b1;
      end
    end
  end

  // While the skid register is occupied tready is low, so no new result arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (push) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_data};

endmodule
`default_nettype wire

// File: sv/stfp_cell.sv
`default_nettype none
module stfp_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] din,
  output logic      [7:0] dout
);

  logic [7:0] char_reg;

  always_ff @(posedge clk) begin
    if (shift) begin
      char_reg <= din;
    end
  end

  assign dout = char_reg;

endmodule
`default_nettype wire

// File: sv/stfp_decode.sv
`default_nettype none
module stfp_decode (
  input  wire stfp_pkg::frame_t  frame,
  input  wire logic              full,
  output stfp_pkg::result_t      result
);

  logic [7:0] hours;
  logic [7:0] minutes;
  logic [7:0] seconds;
  logic       sep_ok;
  logic       range_ok;

  // Each pair is (hi - '0') * 10 + (lo - '0'), kept to eight bits.
  assign hours   = 8'((frame[7] - stfp_pkg::ChZero) * 8'd10) + (frame[6] - stfp_pkg::ChZero);
  assign minutes = 8'((frame[4] - stfp_pkg::ChZero) * 8'd10) + (frame[3] - stfp_pkg::ChZero);
  assign seconds = 8'((frame[1] - stfp_pkg::ChZero) * 8'd10) + (frame[0] - stfp_pkg::ChZero);

  assign sep_ok   = (frame[5] == stfp_pkg::ChSep) && (frame[2] == stfp_pkg::ChSep);
  assign range_ok = (hours < stfp_pkg::HourLimit) && (minutes < stfp_pkg::MinSecLimit)
                    && (seconds < stfp_pkg::MinSecLimit);

  always_comb begin
    result = '0;
    priority if (!full) begin
      result.frame_status = stfp_pkg::STATUS_LEN;
    end else if (!sep_ok) begin
      result.frame_status = stfp_pkg::STATUS_SEP;
    end else if (!range_ok) begin
      result.frame_status = stfp_pkg::STATUS_RANGE;
    end else begin
      result.frame_status = stfp_pkg::STATUS_OK;
      result.hours        = hours;
      result.minutes      = minutes;
      result.seconds      = seconds;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import stfp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 1700;
  localparam int NumRows = 18;

  // One directed frame: text (right-aligned), optional run of filler bytes
  // after the text, then the terminator. The expected time is typed in only
  // where it is obvious; the rest go through the predictor.
  typedef struct packed {
    logic [79:0] text;
    logic [3:0]  text_len;
    logic [7:0]  pad;
    logic [3:0]  pad_n;
    logic [7:0]  term;
    bit          typed;
    result_t     want;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  // Predictor state: the characters held so far in the current line.
  logic [7:0] line_buf [FrameLen];
  logic [3:0] line_len;

  result_t    parsed_times [$];
  result_t    want_time;
  result_t    got_time;
  frame_row_t frame_rows [NumRows];
  int         mismatches = 0;
  int         cycles = 0;
  int         bytes_sent = 0;
  bit         no_gaps = 1'b0;

  serial_time_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic result_t tm(status_t st, int h, int m, int s);
    result_t r;
    r.frame_status = st;
    r.hours = 8'(h);
    r.minutes = 8'(m);
    r.seconds = 8'(s);
    return r;
  endfunction

  // Two characters to a number, wrapping modulo 256 with no digit check.
  function automatic logic [7:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    logic [7:0] a;
    logic [7:0] b;
    a = hi - ChZero;
    b = lo - ChZero;
    return 8'(a * 8'd10 + b);
  endfunction

  function automatic void parse_char(input logic [7:0] c, output bit done,
                                     output result_t r);
    r = tm(STATUS_OK, 0, 0, 0);
    done = 1'b0;
    if (c != ChLf && c != ChCr) begin
      if (line_len < CountFull) begin
        line_buf[line_len[2:0]] = c;
        line_len = line_len + 1'b1;
      end
    end else begin
      done = 1'b1;
      if (line_len != CountFull) begin
        r.frame_status = STATUS_LEN;
      end else if (line_buf[2] != ChSep || line_buf[5] != ChSep) begin
        r.frame_status = STATUS_SEP;
      end else begin
        r.hours = pair_value(line_buf[0], line_buf[1]);
        r.minutes = pair_value(line_buf[3], line_buf[4]);
        r.seconds = pair_value(line_buf[6], line_buf[7]);
        if (!(r.hours < HourLimit && r.minutes < MinSecLimit &&
              r.seconds < MinSecLimit)) begin
          r = tm(STATUS_RANGE, 0, 0, 0);
        end
      end
      line_len = '0;
    end
  endfunction

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChLf || b == ChCr);
    return b;
  endfunction

  task automatic report(string what, logic [7:0] want_v, logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(logic [7:0] b, bit typed, result_t want);
    int gap;
    bit done;
    result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    parse_char(b, done, r);
    if (done) parsed_times.push_back(typed ? want : r);
    bytes_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_time = result_t'(m_tdata[25:0]);
      if (parsed_times.size() == 0) begin
        report("unexpected result, status", 8'hxx, 8'(got_time.frame_status));
      end else begin
        want_time = parsed_times.pop_front();
        if (got_time.frame_status != want_time.frame_status)
          report("frame_status", 8'(want_time.frame_status), 8'(got_time.frame_status));
        if (got_time.hours != want_time.hours)
          report("hours", want_time.hours, got_time.hours);
        if (got_time.minutes != want_time.minutes)
          report("minutes", want_time.minutes, got_time.minutes);
        if (got_time.seconds != want_time.seconds)
          report("seconds", want_time.seconds, got_time.seconds);
      end
    end
  end

  // Result side: a random stall before each transfer, except while no_gaps is set.
  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] fb [$];
    int ln;
    int kind;
    int frames;
    int h;
    int m;
    int s;
    int n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    line_len = '0;
    foreach (line_buf[i]) line_buf[i] = 8'h00;

    frame_rows = '{
      '{"",          0, 8'h00, 0, ChLf, 1'b1, tm(STATUS_LEN, 0, 0, 0)},
      '{"23:59:59",  8, 8'h00, 0, ChCr, 1'b1, tm(STATUS_OK, 23, 59, 59)},
      '{"00:00:00",  8, 8'h00, 0, ChLf, 1'b1, tm(STATUS_OK, 0, 0, 0)},
      '{"24:00:00",  8, 8'h00, 0, ChLf, 1'b1, tm(STATUS_RANGE, 0, 0, 0)},
      '{"00:60:00",  8, 8'h00, 0, ChCr, 1'b1, tm(STATUS_RANGE, 0, 0, 0)},
      '{"00:00:60",  8, 8'h00, 0, ChLf, 1'b1, tm(STATUS_RANGE, 0, 0, 0)},
      '{"12-34:56",  8, 8'h00, 0, ChLf, 1'b1, tm(STATUS_SEP, 0, 0, 0)},
      '{"12:34.56",  8, 8'h00, 0, ChCr, 1'b1, tm(STATUS_SEP, 0, 0, 0)},
      '{"1:2:3",     5, 8'h00, 0, ChLf, 1'b1, tm(STATUS_LEN, 0, 0, 0)},
      '{"12:34:5",   7, 8'h00, 0, ChCr, 1'b1, tm(STATUS_LEN, 0, 0, 0)},
      '{"12:34:56",  8, 8'hFF, 3, ChCr, 1'b1, tm(STATUS_OK, 12, 34, 56)},
      '{"",          0, 8'h00, 8, ChLf, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"",          0, 8'hFF, 8, ChCr, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"I6:00:00",  8, 8'h00, 0, ChLf, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"0/:00:00",  8, 8'h00, 0, ChLf, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"ab:cd:ef",  8, 8'h00, 0, ChCr, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"  :  :  ",  8, 8'h00, 0, ChLf, 1'b0, tm(STATUS_OK, 0, 0, 0)},
      '{"12::34:56", 9, 8'h00, 0, ChCr, 1'b0, tm(STATUS_OK, 0, 0, 0)}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (frame_rows[r]) begin
      ln = frame_rows[r].text_len;
      for (int i = 0; i < ln; i++)
        send_byte(frame_rows[r].text[8*(ln-1-i) +: 8], 1'b0, frame_rows[r].want);
      for (int i = 0; i < frame_rows[r].pad_n; i++)
        send_byte(frame_rows[r].pad, 1'b0, frame_rows[r].want);
      send_byte(frame_rows[r].term, frame_rows[r].typed, frame_rows[r].want);
    end

    frames = 0;
    while (bytes_sent < RandomBytes) begin
      // Now and then a stretch where neither side idles.
      if (frames % 12 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      frames++;
      fb.delete();
      kind = $urandom_range(0, 99);
      h = $urandom_range(0, 23);
      m = $urandom_range(0, 59);
      s = $urandom_range(0, 59);
      if (kind >= 50 && kind < 65) begin
        case ($urandom_range(0, 2))
          0: h = $urandom_range(24, 99);
          1: m = $urandom_range(60, 99);
          default: s = $urandom_range(60, 99);
        endcase
      end
      if (kind < 65) begin
        fb = '{8'(ChZero + h / 10), 8'(ChZero + h % 10), ChSep,
               8'(ChZero + m / 10), 8'(ChZero + m % 10), ChSep,
               8'(ChZero + s / 10), 8'(ChZero + s % 10)};
      end else if (kind < 75) begin
        fb = '{any_char(), any_char(), ChSep, any_char(), any_char(), ChSep,
               any_char(), any_char()};
      end else if (kind < 85) begin
        n = $urandom_range(0, 12);
        repeat (n) fb.push_back(any_char());
      end else if (kind < 95) begin
        fb = '{8'(ChZero + h / 10), 8'(ChZero + h % 10), ChSep,
               8'(ChZero + m / 10), 8'(ChZero + m % 10), ChSep,
               8'(ChZero + s / 10), 8'(ChZero + s % 10)};
        n = $urandom_range(0, 1) ? 2 : 5;
        do fb[n] = any_char(); while (fb[n] == ChSep);
      end else begin
        // Raw noise, terminators included, with no closing terminator.
        n = $urandom_range(1, 6);
        repeat (n) fb.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 95) fb.push_back($urandom_range(0, 1) ? ChLf : ChCr);
      foreach (fb[i]) send_byte(fb[i], 1'b0, tm(STATUS_OK, 0, 0, 0));
    end
    s_tvalid <= 1'b0;

    while (parsed_times.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
